>>> src/unit_triangle_normal_defines.svh
// Assertion macros for the triangle normal pipeline.
// Used by unit_triangle_normal.sv; expects clk_i and rst_ni in scope.
`ifndef UNIT_TRIANGLE_NORMAL_DEFINES_SVH
`define UNIT_TRIANGLE_NORMAL_DEFINES_SVH
`ifndef SYNTHESIS
`define UTN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define UTN_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);
`else
`define UTN_ASSERT(lbl, prop, msg)
`define UTN_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

>>> src/utn_pkg.sv
// Shared constants and types for the triangle normal pipeline.
// No dependencies.
`timescale 1ns / 1ps
package utn_pkg;
  localparam int unsigned EDGE_BITS_DEF        = 24;
  localparam int unsigned NORMAL_FRAC_BITS_DEF = 30;
  localparam int unsigned MAG_BITS             = 31;
  localparam int unsigned SQ_BITS              = 2 * MAG_BITS;
  localparam int unsigned SUM_BITS             = 64;
  localparam int unsigned ROOT_BITS            = 32;
  localparam int unsigned OUT_BITS             = 32;

  typedef struct packed {
    logic [2:0][MAG_BITS-1:0] mag;
    logic [2:0]               neg;
    logic                     deg;
  } side_t;
endpackage

>>> src/unit_triangle_normal.sv
// Unit normal of a triangle: cross product, isqrt and division pipeline.
// Depends on utn_pkg and unit_triangle_normal_defines.svh.
`timescale 1ns / 1ps
`include "unit_triangle_normal_defines.svh"
// One triangle enters per clock unless the output stalls. The pipeline holds
// seven stages for the cross product, scaling and sum of squares, one
// stage per bit of the 32-bit square root, one setup stage and one stage per
// quotient bit of the three parallel restoring dividers, and an output register.
// A stall at the output freezes the whole pipeline; in_ready_o drops only then.
// A zero cross product gives a zero normal with degenerate_o set.
module unit_triangle_normal import utn_pkg::*; #(
  parameter int unsigned EDGE_BITS        = EDGE_BITS_DEF,
  parameter int unsigned NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [EDGE_BITS-1:0] first_edge_x_i,
  input  logic signed [EDGE_BITS-1:0] first_edge_y_i,
  input  logic signed [EDGE_BITS-1:0] first_edge_z_i,
  input  logic signed [EDGE_BITS-1:0] second_edge_x_i,
  input  logic signed [EDGE_BITS-1:0] second_edge_y_i,
  input  logic signed [EDGE_BITS-1:0] second_edge_z_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [OUT_BITS-1:0]  normal_x_o,
  output logic signed [OUT_BITS-1:0]  normal_y_o,
  output logic signed [OUT_BITS-1:0]  normal_z_o,
  output logic                        degenerate_o
);
  localparam int unsigned PB  = 2 * EDGE_BITS;
  localparam int unsigned PW  = PB + 1;
  localparam int unsigned HW  = $clog2(PW + 1);
  localparam int unsigned F   = NORMAL_FRAC_BITS;
  localparam int unsigned QB  = F + 1;
  localparam int unsigned NW  = MAG_BITS + F + 1;
  localparam int unsigned NST = 7 + ROOT_BITS + 1 + QB + 1;
  localparam int unsigned RW  = ROOT_BITS + 3;

  logic           en;
  logic [NST-1:0] v_q;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-2:0], in_valid_i};
    end
  end

  // stage 1: products
  logic signed [PB-1:0] p_q [6];
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0] <= first_edge_y_i * second_edge_z_i;
      p_q[1] <= first_edge_z_i * second_edge_y_i;
      p_q[2] <= first_edge_z_i * second_edge_x_i;
      p_q[3] <= first_edge_x_i * second_edge_z_i;
      p_q[4] <= first_edge_x_i * second_edge_y_i;
      p_q[5] <= first_edge_y_i * second_edge_x_i;
    end
  end

  // stage 2: differences to magnitude and sign
  logic [PW-1:0] mag2_d [3];
  logic [PW-1:0] mag2_q [3];
  logic [2:0]    neg2_d, neg2_q;
  always_comb begin
    logic signed [PW-1:0] c;
    for (int i = 0; i < 3; i++) begin
      c = PW'(p_q[2*i]) - PW'(p_q[2*i+1]);
      neg2_d[i] = c[PW-1];
      mag2_d[i] = c[PW-1] ? PW'(-c) : PW'(c);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      mag2_q <= mag2_d;
      neg2_q <= neg2_d;
    end
  end

  // stage 3: largest magnitude
  logic [PW-1:0] mx_d, mx_q;
  logic [PW-1:0] mag3_q [3];
  logic [2:0]    neg3_q;
  always_comb begin
    mx_d = (mag2_q[0] > mag2_q[1]) ? mag2_q[0] : mag2_q[1];
    mx_d = (mag2_q[2] > mx_d) ? mag2_q[2] : mx_d;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q   <= mx_d;
      mag3_q <= mag2_q;
      neg3_q <= neg2_q;
    end
  end

  // stage 4: leading one
  logic [HW-1:0] sh_d, sh_q;
  logic [PW-1:0] mag4_q [3];
  logic [2:0]    neg4_q;
  logic          deg4_q;
  always_comb begin
    sh_d = '0;
    for (int i = 0; i < PW; i++) begin
      if (mx_q[i]) sh_d = HW'(i + 1);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sh_q   <= sh_d;
      mag4_q <= mag3_q;
      neg4_q <= neg3_q;
      deg4_q <= (mx_q == '0);
    end
  end

  // stage 5: scale top bit to position 30
  side_t s5_d, s5_q;
  always_comb begin
    logic [PW+MAG_BITS-1:0] t;
    for (int i = 0; i < 3; i++) begin
      t = {mag4_q[i], {MAG_BITS{1'b0}}} >> sh_q;
      s5_d.mag[i] = t[MAG_BITS-1:0];
    end
    s5_d.neg = neg4_q;
    s5_d.deg = deg4_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) s5_q <= s5_d;
  end

  // stage 6: squares
  logic [SQ_BITS-1:0] sq_q [3];
  side_t              s6_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sq_q[i] <= s5_q.mag[i] * s5_q.mag[i];
      s6_q <= s5_q;
    end
  end

  // stage 7: sum of squares, then one root bit per stage
  logic [SUM_BITS-1:0]  rx_q   [ROOT_BITS+1];
  logic [RW-3:0]        rrem_q [ROOT_BITS+1];
  logic [ROOT_BITS-1:0] rroot_q[ROOT_BITS+1];
  side_t                rs_q   [ROOT_BITS+1];
  always_ff @(posedge clk_i) begin
    if (en) begin
      rx_q[0]    <= SUM_BITS'(sq_q[0]) + SUM_BITS'(sq_q[1]) + SUM_BITS'(sq_q[2]);
      rrem_q[0]  <= '0;
      rroot_q[0] <= '0;
      rs_q[0]    <= s6_q;
    end
  end

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
    logic [RW-1:0] rn, trial;
    logic          ge;
    assign rn    = {rrem_q[k], rx_q[k][SUM_BITS-1 -: 2]};
    assign trial = RW'({rroot_q[k], 2'b01});
    assign ge    = (rn >= trial);
    always_ff @(posedge clk_i) begin
      if (en) begin
        rx_q[k+1]    <= {rx_q[k][SUM_BITS-3:0], 2'b00};
        rrem_q[k+1]  <= ge ? (RW-2)'(rn - trial) : (RW-2)'(rn);
        rroot_q[k+1] <= {rroot_q[k][ROOT_BITS-2:0], ge};
        rs_q[k+1]    <= rs_q[k];
      end
    end
  end

  // divider setup and one quotient bit per stage
  logic [ROOT_BITS-1:0] dl_q  [QB+1];
  logic [ROOT_BITS-1:0] drem_q[QB+1][3];
  logic [QB-1:0]        dlow_q[QB+1][3];
  logic [QB-1:0]        dq_q  [QB+1][3];
  logic [2:0]           dneg_q[QB+1];
  logic                 ddeg_q[QB+1];
  always_ff @(posedge clk_i) begin
    logic [NW-1:0] num;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num = {rs_q[ROOT_BITS].mag[i], {F{1'b0}}}
              + NW'(rroot_q[ROOT_BITS] >> 1);
        drem_q[0][i] <= ROOT_BITS'(num >> QB);
        dlow_q[0][i] <= num[QB-1:0];
        dq_q[0][i]   <= '0;
      end
      dl_q[0]   <= rroot_q[ROOT_BITS];
      dneg_q[0] <= rs_q[ROOT_BITS].neg;
      ddeg_q[0] <= rs_q[ROOT_BITS].deg;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [ROOT_BITS:0] rn;
      logic               ge;
      assign rn = {drem_q[j][i], dlow_q[j][i][QB-1]};
      assign ge = (rn >= {1'b0, dl_q[j]});
      always_ff @(posedge clk_i) begin
        if (en) begin
          drem_q[j+1][i] <= ge ? ROOT_BITS'(rn - {1'b0, dl_q[j]}) : rn[ROOT_BITS-1:0];
          dlow_q[j+1][i] <= dlow_q[j][i] << 1;
          dq_q[j+1][i]   <= {dq_q[j][i][QB-2:0], ge};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dl_q[j+1]   <= dl_q[j];
        dneg_q[j+1] <= dneg_q[j];
        ddeg_q[j+1] <= ddeg_q[j];
      end
    end
  end

  // output register
  logic [OUT_BITS-1:0] nrm_q [3];
  logic                deg_q;
  always_ff @(posedge clk_i) begin
    logic [OUT_BITS-1:0] qv;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        qv = OUT_BITS'(dq_q[QB][i]);
        if (ddeg_q[QB]) nrm_q[i] <= '0;
        else            nrm_q[i] <= dneg_q[QB][i] ? OUT_BITS'(-qv) : qv;
      end
      deg_q <= ddeg_q[QB];
    end
  end

  assign out_valid_o  = v_q[NST-1];
  assign normal_x_o   = nrm_q[0];
  assign normal_y_o   = nrm_q[1];
  assign normal_z_o   = nrm_q[2];
  assign degenerate_o = deg_q;

  localparam logic signed [OUT_BITS-1:0] ONE = OUT_BITS'(1) << F;

  `UTN_ASSERT(a_deg_zero, out_valid_o && degenerate_o |-> normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0, "degenerate result not zero")
  `UTN_ASSERT(a_unit_range, out_valid_o && !degenerate_o |-> normal_x_o <= ONE && normal_x_o >= -ONE && normal_z_o <= ONE && normal_z_o >= -ONE, "normal out of range")
  `UTN_ASSERT(a_root_min, v_q[ROOT_BITS+6] && !rs_q[ROOT_BITS].deg |-> rroot_q[ROOT_BITS][ROOT_BITS-1:F] != '0 || rroot_q[ROOT_BITS][MAG_BITS-1], "root below scale")
  `UTN_ASSERT_NEXT(a_stall_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(v_q), "pipeline moved under stall")
endmodule
